FILE: sv/stc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg: shared constants, a type and a function
// Reciprocal constants for the constant divisions, calendar constants, the
// month start table and the record that passes between the two halves.
// ----------------------------------------------------------------------------
package stc_pkg;

	localparam int unsigned SecondsW = 32;

	// floor(x / 60) == (x * RecipDiv60) >> Div60Shift for every 32-bit x.
	localparam logic [31:0] RecipDiv60 = 32'h8888_8889;
	localparam int unsigned Div60Shift = 37;

	// floor(x / 3) == (x * RecipDiv3) >> Div3Shift for every 32-bit x.
	localparam logic [31:0] RecipDiv3 = 32'hAAAA_AAAB;
	localparam int unsigned Div3Shift = 33;

	// floor(x / 1461) == (x * RecipDiv1461) >> Div1461Shift for every 16-bit x.
	localparam logic [15:0] RecipDiv1461 = 16'd45934;
	localparam int unsigned Div1461Shift = 26;

	localparam int unsigned SecsPerMin = 60;
	localparam int unsigned HoursPerDay = 24;
	localparam int unsigned DaysPerYear = 365;
	localparam int unsigned DaysLeapYear = DaysPerYear + 1;
	localparam int unsigned DaysPerCycle = 4 * DaysPerYear + 1;
	localparam int unsigned BaseYear = 2000;

	// Time of day plus the whole-day count, handed from the time half to the
	// date half.
	typedef struct packed {
		logic [15:0] days;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} stc_mid_t;

	// First 0-based day of month m (0 is January); one day later from March on
	// in a leap year.
	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] s;
		case (m)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd59;
			4'd3:    s = 9'd90;
			4'd4:    s = 9'd120;
			4'd5:    s = 9'd151;
			4'd6:    s = 9'd181;
			4'd7:    s = 9'd212;
			4'd8:    s = 9'd243;
			4'd9:    s = 9'd273;
			4'd10:   s = 9'd304;
			default: s = 9'd334;
		endcase
		if (leap && (m >= 4'd2)) begin
			s = s + 9'd1;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

FILE: sv/stc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_in_if / stc_out_if: valid-ready channels
// The input channel carries a seconds count, the output channel a date.
// ----------------------------------------------------------------------------
interface stc_in_if import stc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SecondsW-1:0] seconds_since_2000;

	modport source(output valid, output seconds_since_2000, input ready);
	modport sink(input valid, input seconds_since_2000, output ready);
endinterface

interface stc_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  second_of_minute;
	logic [5:0]  minute_of_hour;
	logic [4:0]  hour_of_day;
	logic [4:0]  day_of_month;
	logic [3:0]  month_of_year;
	logic [11:0] full_year;
	logic        is_leap;

	modport source(output valid, output second_of_minute, output minute_of_hour,
		output hour_of_day, output day_of_month, output month_of_year,
		output full_year, output is_leap, input ready);
	modport sink(input valid, input second_of_minute, input minute_of_hour,
		input hour_of_day, input day_of_month, input month_of_year,
		input full_year, input is_leap, output ready);
endinterface
`default_nettype wire

FILE: sv/stc_time_split.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_time_split: seconds count to time of day and day count
// Four stages: divide by 60, divide by 60, divide by 24, hour remainder.
// ----------------------------------------------------------------------------
module stc_time_split import stc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	stc_in_if.sink     stamp,
	output logic       mid_valid,
	input  wire logic  mid_ready,
	output stc_mid_t   mid
);

	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [63:0] prod1, prod2, prod3;
	logic [11:0] mul_sec, mul_min;
	logic [9:0]  mul_hour;

	logic [26:0] quo_s1;
	logic [5:0]  tlo_s1;
	logic [20:0] quo_s2;
	logic [5:0]  qlo_s2;
	logic [5:0]  sec_s2;
	logic [15:0] days_s3;
	logic [4:0]  hlo_s3;
	logic [5:0]  min_s3;
	logic [5:0]  sec_s3;
	stc_mid_t    mid_s4;

	// A stage moves when it is empty or the stage after it moves.
	assign en4 = !v_s4 || mid_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign stamp.ready = en1;

	assign prod1 = {32'd0, stamp.seconds_since_2000} * {32'd0, RecipDiv60};
	assign prod2 = {37'd0, quo_s1} * {32'd0, RecipDiv60};
	assign prod3 = {46'd0, quo_s2[20:3]} * {32'd0, RecipDiv3};

	// Remainders only need the low bits, since each one is below 64.
	assign mul_sec  = {6'd0, quo_s1[5:0]} * 12'(SecsPerMin);
	assign mul_min  = {6'd0, quo_s2[5:0]} * 12'(SecsPerMin);
	assign mul_hour = {5'd0, days_s3[4:0]} * 10'(HoursPerDay);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= stamp.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && stamp.valid) begin
			quo_s1 <= prod1[63:Div60Shift];
			tlo_s1 <= stamp.seconds_since_2000[5:0];
		end
		if (en2 && v_s1) begin
			quo_s2 <= prod2[Div60Shift+20:Div60Shift];
			qlo_s2 <= quo_s1[5:0];
			sec_s2 <= tlo_s1 - mul_sec[5:0];
		end
		if (en3 && v_s2) begin
			days_s3 <= prod3[Div3Shift+15:Div3Shift];
			hlo_s3  <= quo_s2[4:0];
			min_s3  <= qlo_s2 - mul_min[5:0];
			sec_s3  <= sec_s2;
		end
		if (en4 && v_s3) begin
			mid_s4.days   <= days_s3;
			mid_s4.hour   <= hlo_s3 - mul_hour[4:0];
			mid_s4.minute <= min_s3;
			mid_s4.second <= sec_s3;
		end
	end

	assign mid_valid = v_s4;
	assign mid       = mid_s4;

	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (sec_s3 < 6'(SecsPerMin)) && (min_s3 < 6'(SecsPerMin)))
		else $error("time split: second or minute out of range");

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (mid_s4.hour < 5'(HoursPerDay)) && (mid_s4.days <= 16'd49710))
		else $error("time split: hour or day count out of range");

	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mid_valid && !mid_ready |=> mid_valid && $stable(mid))
		else $error("time split: stalled output changed");

endmodule
`default_nettype wire

FILE: sv/stc_date_split.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_date_split: day count to year, month and day of month
// Four stages: four-year cycle, day within cycle, year and day of year,
// month search and output register.
// ----------------------------------------------------------------------------
module stc_date_split import stc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     mid_valid,
	output logic          mid_ready,
	input  wire stc_mid_t mid,
	stc_out_if.source     date
);

	logic en1, en2, en3, en4;
	logic v_d1, v_d2, v_d3, v_d4;

	logic [31:0] prod_cyc;
	logic [15:0] cyc_days;
	logic [10:0] rest;
	logic [1:0]  yic;
	logic [8:0]  doy;
	logic        leap;
	logic [3:0]  month_idx;
	logic [8:0]  mstart;

	stc_mid_t    mid_d1;
	logic [5:0]  cyc_d1;
	stc_mid_t    mid_d2;
	logic [10:0] rem_d2;
	logic [5:0]  cyc_d2;
	stc_mid_t    mid_d3;
	logic [8:0]  doy_d3;
	logic        leap_d3;
	logic [11:0] year_d3;

	assign en4 = !v_d4 || date.ready;
	assign en3 = !v_d3 || en4;
	assign en2 = !v_d2 || en3;
	assign en1 = !v_d1 || en2;
	assign mid_ready = en1;

	assign prod_cyc = {16'd0, mid.days} * {16'd0, RecipDiv1461};
	assign cyc_days = {10'd0, cyc_d1} * 16'(DaysPerCycle);

	// Leap year first in each cycle, then three common years.
	always_comb begin
		rest = 11'd0;
		yic  = 2'd0;
		doy  = rem_d2[8:0];
		leap = 1'b1;
		if (rem_d2 >= 11'(DaysLeapYear)) begin
			leap = 1'b0;
			rest = rem_d2 - 11'(DaysLeapYear);
			if (rest < 11'(DaysPerYear)) begin
				yic = 2'd1;
				doy = rest[8:0];
			end else if (rest < 11'(2 * DaysPerYear)) begin
				yic = 2'd2;
				doy = 9'(rest - 11'(DaysPerYear));
			end else begin
				yic = 2'd3;
				doy = 9'(rest - 11'(2 * DaysPerYear));
			end
		end
	end

	// The month starts rise, so the month index is the number of later months
	// that have already begun.
	always_comb begin
		month_idx = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy_d3 >= month_start(4'(k), leap_d3)) begin
				month_idx = month_idx + 4'd1;
			end
		end
	end
	assign mstart = month_start(month_idx, leap_d3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d1 <= 1'b0;
			v_d2 <= 1'b0;
			v_d3 <= 1'b0;
			v_d4 <= 1'b0;
		end else begin
			if (en1) v_d1 <= mid_valid;
			if (en2) v_d2 <= v_d1;
			if (en3) v_d3 <= v_d2;
			if (en4) v_d4 <= v_d3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && mid_valid) begin
			mid_d1 <= mid;
			cyc_d1 <= prod_cyc[Div1461Shift+5:Div1461Shift];
		end
		if (en2 && v_d1) begin
			mid_d2 <= mid_d1;
			cyc_d2 <= cyc_d1;
			rem_d2 <= 11'(mid_d1.days - cyc_days);
		end
		if (en3 && v_d2) begin
			mid_d3  <= mid_d2;
			doy_d3  <= doy;
			leap_d3 <= leap;
			year_d3 <= 12'(BaseYear) + {4'd0, cyc_d2, 2'b00} + {10'd0, yic};
		end
		if (en4 && v_d3) begin
			date.second_of_minute <= mid_d3.second;
			date.minute_of_hour   <= mid_d3.minute;
			date.hour_of_day      <= mid_d3.hour;
			date.day_of_month     <= 5'(doy_d3 - mstart + 9'd1);
			date.month_of_year    <= month_idx + 4'd1;
			date.full_year        <= year_d3;
			date.is_leap          <= leap_d3;
		end
	end

	assign date.valid = v_d4;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_d2 |-> (rem_d2 < 11'(DaysPerCycle)))
		else $error("date split: day within cycle out of range");

	a_doy_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_d3 |-> (doy_d3 < (leap_d3 ? 9'(DaysLeapYear) : 9'(DaysPerYear))))
		else $error("date split: day of year out of range");

	a_date_fields: assert property (@(posedge clk) disable iff (!arst_n)
		date.valid |-> (date.month_of_year >= 4'd1) && (date.month_of_year <= 4'd12)
			&& (date.day_of_month >= 5'd1))
		else $error("date split: month or day out of range");

	a_leap_flag: assert property (@(posedge clk) disable iff (!arst_n)
		date.valid |-> (date.is_leap == (date.full_year[1:0] == 2'b00)))
		else $error("date split: leap flag disagrees with year");

endmodule
`default_nettype wire

FILE: sv/seconds_to_calendar_date_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_core: seconds since 2000 to calendar date
// Splits a 32-bit count of seconds since 2000-01-01 00:00:00 into second,
// minute, hour, day of month, month, full year and a leap flag. Every fourth
// year from 2000 is a leap year.
// ----------------------------------------------------------------------------
//
//  Channel  Role    Payload
//  -------  ------  ---------------------------------------------------------
//  stamp    sink    seconds_since_2000 (32 bits)
//  date     source  second_of_minute, minute_of_hour, hour_of_day,
//                   day_of_month, month_of_year, full_year, is_leap
//
// One transaction enters per clock cycle while no stall on date.ready reaches
// the input. It passes four stages in the time half (two divisions by 60 and
// one by 24, each a reciprocal multiply, then the hour remainder) and four in
// the date half (four-year cycle, day within the cycle, year, month search).
// Reset clears only the valid bits of the eight stages; no data is cleared.
// A stage advances when it is empty or the stage after it advances, so a
// stall on date.ready holds every full stage in place while empty stages
// still fill, and no transaction is lost or repeated.
//
module seconds_to_calendar_date_core import stc_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	stc_in_if.sink    stamp,
	stc_out_if.source date
);

	// Time of day and whole-day count between the two halves.
	logic     mid_valid;
	logic     mid_ready;
	stc_mid_t mid;

	stc_time_split u_time (
		.clk       (clk),
		.arst_n    (arst_n),
		.stamp     (stamp),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid)
	);

	stc_date_split u_date (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid),
		.date      (date)
	);

endmodule
`default_nettype wire
